>>> hdl/motion_command_safety_interlock_macros.svh
// motion_command_safety_interlock_macros.svh
// assertion shorthands for the interlock; expects clk_i and rst_ni in scope
`ifndef MOTION_COMMAND_SAFETY_INTERLOCK_MACROS_SVH
`define MOTION_COMMAND_SAFETY_INTERLOCK_MACROS_SVH

// same-cycle implication
`define MCSI_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCSI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mcsi_pkg.sv
// mcsi_pkg.sv
// types, codes and constants shared by the motion command safety interlock
// no dependencies
package mcsi_pkg;

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_HEARTBEAT = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_BRAKE     = 3'd3,
    CMD_ARM       = 3'd4,
    CMD_MOVE      = 3'd5,
    CMD_HEAD      = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    ACK_NONE           = 4'd0,
    ACK_ARM_OFF        = 4'd1,
    ACK_ARM_ON         = 4'd2,
    ACK_REJ_MANUAL     = 4'd3,
    ACK_REJ_ROBOT      = 4'd4,
    ACK_REJ_DISARMED   = 4'd5,
    ACK_REJ_SONAR      = 4'd6,
    ACK_REJ_DIRECTION  = 4'd7,
    ACK_MOVE_OK        = 4'd8,
    ACK_STOP_OK        = 4'd9,
    ACK_BRAKE_OK       = 4'd10,
    ACK_HEAD_OK        = 4'd11,
    ACK_REJ_NO_HEAD    = 4'd12,
    ACK_REJ_HEAD_LOCK  = 4'd13,
    ACK_DISARM_MANUAL  = 4'd14,
    ACK_DISARM_HB      = 4'd15
  } ack_e;

  typedef enum logic [2:0] {
    MOTOR_NONE    = 3'd0,
    MOTOR_STOP    = 3'd1,
    MOTOR_FORWARD = 3'd2,
    MOTOR_BACK    = 3'd3,
    MOTOR_LEFT    = 3'd4,
    MOTOR_RIGHT   = 3'd5
  } motor_e;

  typedef enum logic [1:0] {
    REG_HB_TIMEOUT   = 2'd0,
    REG_MAX_MOVE     = 2'd1,
    REG_HEAD_PRESENT = 2'd2
  } reg_e;

  localparam int unsigned PaddrWidth = 4;

  localparam logic [15:0] HbTimeoutReset   = 16'd1200;
  localparam logic [15:0] MaxMoveReset     = 16'd350;
  localparam logic        HeadPresentReset = 1'b1;

  localparam logic [7:0] DirForward = 8'd70;
  localparam logic [7:0] DirBack    = 8'd66;
  localparam logic [7:0] DirLeft    = 8'd76;
  localparam logic [7:0] DirRight   = 8'd82;

  localparam logic signed [15:0] MinMoveMs = 16'sd50;
  localparam logic signed [15:0] PanMin    = 16'sd10;
  localparam logic signed [15:0] PanMax    = 16'sd170;
  localparam logic signed [15:0] TiltMin   = 16'sd5;
  localparam logic signed [15:0] TiltMax   = 16'sd150;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        now_ms;
    logic               arm_value;
    logic [7:0]         move_dir;
    logic signed [15:0] move_duration_ms;
    logic signed [15:0] head_pan;
    logic signed [15:0] head_tilt;
    logic               manual_active;
    logic               robot_mode_active;
    logic               forward_safe;
  } in_word_t;

  typedef struct packed {
    logic [3:0] ack_code;
    logic [2:0] motor_cmd;
    logic       head_write;
    logic [7:0] head_pan_out;
    logic [7:0] head_tilt_out;
    logic       armed_out;
    logic       moving_out;
  } out_word_t;

  typedef struct packed {
    logic        armed;
    logic        move_active;
    logic [31:0] move_deadline;
    logic [31:0] last_heartbeat;
  } link_state_t;

  typedef struct packed {
    logic [15:0] hb_timeout_ms;
    logic [15:0] max_move_ms;
    logic        head_present;
  } cfg_t;

endpackage

>>> hdl/mcsi_decide.sv
// mcsi_decide.sv
// one command against the link state: acknowledgement, motor and head words, next state
// depends on mcsi_pkg
module mcsi_decide (
  input  mcsi_pkg::in_word_t    item_i,
  input  mcsi_pkg::link_state_t state_i,
  input  mcsi_pkg::cfg_t        cfg_i,
  output mcsi_pkg::out_word_t   result_o,
  output mcsi_pkg::link_state_t state_o
);

  logic [31:0] hb_age;
  logic [31:0] to_deadline;
  logic        hb_expired;
  logic        deadline_hit;
  logic        stop_if_moving;
  logic [15:0] dur_clamped;
  logic [7:0]  pan_clamped;
  logic [7:0]  tilt_clamped;

  assign hb_age       = item_i.now_ms - state_i.last_heartbeat;
  assign to_deadline  = item_i.now_ms - state_i.move_deadline;
  assign hb_expired   = hb_age > {16'b0, cfg_i.hb_timeout_ms};
  assign deadline_hit = !to_deadline[31];
  // motor stop when a running move is cancelled and manual control is off
  assign stop_if_moving = state_i.move_active && !item_i.manual_active;

  always_comb begin
    if (item_i.move_duration_ms < mcsi_pkg::MinMoveMs) begin
      dur_clamped = 16'(mcsi_pkg::MinMoveMs);
    end else if (16'(item_i.move_duration_ms) > cfg_i.max_move_ms) begin
      dur_clamped = cfg_i.max_move_ms;
    end else begin
      dur_clamped = 16'(item_i.move_duration_ms);
    end
  end

  always_comb begin
    if (item_i.head_pan < mcsi_pkg::PanMin) begin
      pan_clamped = mcsi_pkg::PanMin[7:0];
    end else if (item_i.head_pan > mcsi_pkg::PanMax) begin
      pan_clamped = mcsi_pkg::PanMax[7:0];
    end else begin
      pan_clamped = item_i.head_pan[7:0];
    end
    if (item_i.head_tilt < mcsi_pkg::TiltMin) begin
      tilt_clamped = mcsi_pkg::TiltMin[7:0];
    end else if (item_i.head_tilt > mcsi_pkg::TiltMax) begin
      tilt_clamped = mcsi_pkg::TiltMax[7:0];
    end else begin
      tilt_clamped = item_i.head_tilt[7:0];
    end
  end

  always_comb begin
    mcsi_pkg::ack_e   ack;
    mcsi_pkg::motor_e motor;
    logic             hw;
    logic             cancel;
    ack    = mcsi_pkg::ACK_NONE;
    motor  = mcsi_pkg::MOTOR_NONE;
    hw     = 1'b0;
    cancel = 1'b0;
    state_o = state_i;

    case (mcsi_pkg::cmd_e'(item_i.command))
      mcsi_pkg::CMD_TICK: begin
        if (item_i.manual_active && state_i.armed) begin
          state_o.armed = 1'b0;
          cancel        = 1'b1;
          ack           = mcsi_pkg::ACK_DISARM_MANUAL;
        end else if (state_i.armed && hb_expired) begin
          if (stop_if_moving) motor = mcsi_pkg::MOTOR_STOP;
          state_o.armed = 1'b0;
          cancel        = 1'b1;
          ack           = mcsi_pkg::ACK_DISARM_HB;
        end else if (state_i.move_active && deadline_hit) begin
          if (stop_if_moving) motor = mcsi_pkg::MOTOR_STOP;
          cancel = 1'b1;
        end
      end
      mcsi_pkg::CMD_HEARTBEAT: begin
        state_o.last_heartbeat = item_i.now_ms;
      end
      mcsi_pkg::CMD_STOP: begin
        cancel        = 1'b1;
        state_o.armed = 1'b0;
        motor         = mcsi_pkg::MOTOR_STOP;
        ack           = mcsi_pkg::ACK_STOP_OK;
      end
      mcsi_pkg::CMD_BRAKE: begin
        if (stop_if_moving) motor = mcsi_pkg::MOTOR_STOP;
        cancel = 1'b1;
        ack    = mcsi_pkg::ACK_BRAKE_OK;
      end
      mcsi_pkg::CMD_ARM: begin
        if (!item_i.arm_value) begin
          if (stop_if_moving) motor = mcsi_pkg::MOTOR_STOP;
          cancel        = 1'b1;
          state_o.armed = 1'b0;
          ack           = mcsi_pkg::ACK_ARM_OFF;
        end else if (item_i.manual_active) begin
          ack = mcsi_pkg::ACK_REJ_MANUAL;
        end else if (item_i.robot_mode_active) begin
          ack = mcsi_pkg::ACK_REJ_ROBOT;
        end else begin
          state_o.armed          = 1'b1;
          state_o.last_heartbeat = item_i.now_ms;
          ack                    = mcsi_pkg::ACK_ARM_ON;
        end
      end
      mcsi_pkg::CMD_MOVE: begin
        if (!state_i.armed) begin
          ack = mcsi_pkg::ACK_REJ_DISARMED;
        end else if (item_i.manual_active) begin
          state_o.armed = 1'b0;
          cancel        = 1'b1;
          ack           = mcsi_pkg::ACK_REJ_MANUAL;
        end else if (item_i.robot_mode_active) begin
          ack = mcsi_pkg::ACK_REJ_ROBOT;
        end else if (item_i.move_dir == mcsi_pkg::DirForward && !item_i.forward_safe) begin
          // blocked ahead: stop but keep the move state as it is
          motor = mcsi_pkg::MOTOR_STOP;
          ack   = mcsi_pkg::ACK_REJ_SONAR;
        end else if (item_i.move_dir == mcsi_pkg::DirForward ||
                     item_i.move_dir == mcsi_pkg::DirBack ||
                     item_i.move_dir == mcsi_pkg::DirLeft ||
                     item_i.move_dir == mcsi_pkg::DirRight) begin
          if (item_i.move_dir == mcsi_pkg::DirForward) begin
            motor = mcsi_pkg::MOTOR_FORWARD;
          end else if (item_i.move_dir == mcsi_pkg::DirBack) begin
            motor = mcsi_pkg::MOTOR_BACK;
          end else if (item_i.move_dir == mcsi_pkg::DirLeft) begin
            motor = mcsi_pkg::MOTOR_LEFT;
          end else begin
            motor = mcsi_pkg::MOTOR_RIGHT;
          end
          state_o.move_active   = 1'b1;
          state_o.move_deadline = item_i.now_ms + {16'b0, dur_clamped};
          ack                   = mcsi_pkg::ACK_MOVE_OK;
        end else begin
          ack = mcsi_pkg::ACK_REJ_DIRECTION;
        end
      end
      mcsi_pkg::CMD_HEAD: begin
        if (!state_i.armed || item_i.manual_active || item_i.robot_mode_active) begin
          ack = mcsi_pkg::ACK_REJ_HEAD_LOCK;
        end else if (!cfg_i.head_present) begin
          ack = mcsi_pkg::ACK_REJ_NO_HEAD;
        end else begin
          hw  = 1'b1;
          ack = mcsi_pkg::ACK_HEAD_OK;
        end
      end
      default: begin
      end
    endcase

    if (cancel) begin
      state_o.move_active   = 1'b0;
      state_o.move_deadline = 32'd0;
    end

    result_o.ack_code      = ack;
    result_o.motor_cmd     = motor;
    result_o.head_write    = hw;
    result_o.head_pan_out  = hw ? pan_clamped : 8'd0;
    result_o.head_tilt_out = hw ? tilt_clamped : 8'd0;
    result_o.armed_out     = state_o.armed;
    result_o.moving_out    = state_o.move_active;
  end

endmodule

>>> hdl/motion_command_safety_interlock.sv
// Motion command safety interlock. Takes one decoded command word per cycle, checks it
// against the armed flag, move deadline and heartbeat age, and returns one result word
// (acknowledgement code, motor command, clamped head angles, flags after the command).
// A word moves through an input register and a result register, so a result word is
// offered once its command has passed both registers, and one command per cycle is sustained
// as long as results are taken; the link state is updated as a word crosses the decision
// logic between the two registers. Timeouts are checked on tick commands only.
// Registers sit on a small APB port at 0x0 (heartbeat timeout), 0x4 (max move time)
// and 0x8 (head present); write them only while no command is in flight.
module motion_command_safety_interlock (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcsi_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mcsi_pkg::out_word_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [mcsi_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  `include "motion_command_safety_interlock_macros.svh"

  logic                  in_v_q;
  mcsi_pkg::in_word_t    in_q;
  logic                  out_v_q;
  mcsi_pkg::out_word_t   out_q;
  mcsi_pkg::link_state_t state_q, state_d;
  mcsi_pkg::cfg_t        cfg_q;
  mcsi_pkg::out_word_t   result;
  logic                  advance;
  logic                  cfg_wr;
  mcsi_pkg::reg_e        reg_sel;

  // word leaves the input register when the result register is free or draining
  assign advance    = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || advance;

  mcsi_decide u_decide (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .result_o (result),
    .state_o  (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (in_ready_o) in_v_q <= in_valid_i;
      if (advance) begin
        out_v_q <= 1'b1;
        state_q <= state_d;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
    if (advance) out_q <= result;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = mcsi_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hb_timeout_ms <= mcsi_pkg::HbTimeoutReset;
      cfg_q.max_move_ms   <= mcsi_pkg::MaxMoveReset;
      cfg_q.head_present  <= mcsi_pkg::HeadPresentReset;
    end else if (cfg_wr) begin
      case (reg_sel)
        mcsi_pkg::REG_HB_TIMEOUT:   cfg_q.hb_timeout_ms <= pwdata[15:0];
        mcsi_pkg::REG_MAX_MOVE:     cfg_q.max_move_ms   <= pwdata[15:0];
        mcsi_pkg::REG_HEAD_PRESENT: cfg_q.head_present  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mcsi_pkg::REG_HB_TIMEOUT:   prdata = {16'b0, cfg_q.hb_timeout_ms};
      mcsi_pkg::REG_MAX_MOVE:     prdata = {16'b0, cfg_q.max_move_ms};
      mcsi_pkg::REG_HEAD_PRESENT: prdata = {31'b0, cfg_q.head_present};
      default:                    prdata = 32'd0;
    endcase
  end

  // a move can only be running on an armed link
  `MCSI_ASSERT_IMPL(a_move_needs_arm, !state_q.armed, !state_q.move_active, "move active while disarmed")
  // head angles go out only with the driver fitted
  `MCSI_ASSERT_IMPL(a_head_needs_driver, advance && result.head_write, cfg_q.head_present, "head write without driver")
  // input side stalls only behind a held result
  `MCSI_ASSERT_IMPL(a_stall_cause, !in_ready_o, in_v_q && out_v_q && !out_ready_i, "input stalled without cause")
  // every decided word lands in the result register
  `MCSI_ASSERT_NEXT(a_result_loaded, advance, out_v_q, "decided word not held")
  // reported flags follow the committed state
  `MCSI_ASSERT_NEXT(a_flags_match, advance, out_q.armed_out == state_q.armed && out_q.moving_out == state_q.move_active, "result flags differ from state")

endmodule
